// ----- design/gspd_pkg.sv -----
package gspd_pkg;

  // image and control law constants
  localparam int unsigned IMAGE_COLUMNS = 128;
  localparam int signed   BAND_EDGE     = 17;
  localparam int unsigned KP_RIGHT_SIDE = 19;
  localparam int unsigned KP_LEFT_SIDE  = 13;
  localparam int unsigned KD_BASE       = 40;
  localparam int unsigned KP_OBST_LEFT  = 18;
  localparam int unsigned KP_OBST_RIGHT = 22;
  localparam int unsigned KD_OBST       = 35;
  localparam int unsigned DUTY_SPAN     = 1200;
  localparam int unsigned DUTY_MAX      = 32767;

  localparam int unsigned COL_W   = 7;
  localparam int unsigned DUTY_W  = 15;
  localparam int unsigned EXTRA_W = 6;
  localparam int unsigned ERR_W   = 8;
  localparam int unsigned GAIN_W  = 7;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned CIDX_W  = 2;

  // register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_TARGET_COLUMN = 2'd0,
    REG_DUTY_CENTER   = 2'd1,
    REG_KP_EXTRA      = 2'd2,
    REG_KD_EXTRA      = 2'd3
  } cfg_index_t;

  localparam logic [COL_W-1:0]   TARGET_RESET = 7'd55;
  localparam logic [DUTY_W-1:0]  CENTER_RESET = 15'd4520;
  localparam logic [EXTRA_W-1:0] KP_X_RESET   = 6'd6;
  localparam logic [EXTRA_W-1:0] KD_X_RESET   = 6'd25;

  typedef struct packed {
    logic [COL_W-1:0]   target_column;
    logic [DUTY_W-1:0]  duty_center;
    logic [EXTRA_W-1:0] kp_extra;
    logic [EXTRA_W-1:0] kd_extra;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] line_column;
    logic             obstacle_left;
    logic             obstacle_right;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       steer_duty;
    logic signed [ERR_W-1:0] steer_error;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
  } gains_t;

endpackage

// ----- design/gain_scheduled_pd_steering.sv -----
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data  (line column, obstacle flags)
// out      output     out_valid / out_ready  out_data (steering duty, steer error)
// cfg      input      cfg_write              cfg_index, cfg_data
//
// two register stages: an input register and a result register, with the
// gain schedule, the pd terms and the clamp combinational between them
// one item per cycle sustained while out_ready holds; an accepted item waits
// in the input register, then moves to the result register, raising out_valid
// in_ready stays high while the input register is empty or can move on, so a
// waiting result stalls input only once both stages hold an item
// synchronous active-high reset clears both stages, the held gains, the
// previous error, and loads the register defaults
module gain_scheduled_pd_steering (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gspd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gspd_pkg::out_item_t             out_data,
  input  logic                            cfg_write,
  input  logic [gspd_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [gspd_pkg::CFG_W-1:0]      cfg_data
);

  localparam logic [gspd_pkg::COL_W-1:0] COL_LAST =
    gspd_pkg::COL_W'(gspd_pkg::IMAGE_COLUMNS - 1);

  gspd_pkg::cfg_t                    cfg;
  gspd_pkg::gains_t                  gains;
  gspd_pkg::in_item_t                s1_item;
  logic                              s1_valid;
  logic                              s1_advance;
  logic [gspd_pkg::COL_W-1:0]        col_sat;
  logic signed [gspd_pkg::ERR_W-1:0] err;
  logic signed [gspd_pkg::ERR_W-1:0] previous_error;
  logic [gspd_pkg::DUTY_W-1:0]       duty;

  // config registers
  gspd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: stage one moves when the result register is free or emptying
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // columns past the image edge pin to the last column
  always_comb begin
    col_sat = s1_item.line_column;
    if (32'(s1_item.line_column) >= gspd_pkg::IMAGE_COLUMNS) begin
      col_sat = COL_LAST;
    end
  end

  assign err = $signed({1'b0, col_sat}) - $signed({1'b0, cfg.target_column});

  // gain schedule with held gains
  gspd_gain_sched u_gain (
    .clk            (clk),
    .rst            (rst),
    .advance        (s1_advance),
    .err            (err),
    .obstacle_left  (s1_item.obstacle_left),
    .obstacle_right (s1_item.obstacle_right),
    .cfg            (cfg),
    .gains          (gains)
  );

  // pd law and clamp
  gspd_pd_calc u_pd (
    .err         (err),
    .prev_err    (previous_error),
    .gains       (gains),
    .duty_center (cfg.duty_center),
    .steer_duty  (duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
    end else if (s1_advance) begin
      previous_error <= err;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data.steer_duty  <= duty;
      out_data.steer_error <= err;
    end
  end

  // a result always follows the stage-one move
  a_advance_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("stage one moved but no result appeared");

  // the shown error is the one the derivative term will use next
  a_prev_matches_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.steer_error == previous_error)
    else $error("previous error out of step with result");

  // a blocked input register keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_item))
    else $error("stalled item lost from input register");

endmodule

// ----- design/gspd_cfg.sv -----
module gspd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gspd_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [gspd_pkg::CFG_W-1:0]      cfg_data,
  output gspd_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_column <= gspd_pkg::TARGET_RESET;
      cfg.duty_center   <= gspd_pkg::CENTER_RESET;
      cfg.kp_extra      <= gspd_pkg::KP_X_RESET;
      cfg.kd_extra      <= gspd_pkg::KD_X_RESET;
    end else if (cfg_write) begin
      unique case (gspd_pkg::cfg_index_t'(cfg_index))
        gspd_pkg::REG_TARGET_COLUMN:
          cfg.target_column <= cfg_data[gspd_pkg::COL_W-1:0];
        gspd_pkg::REG_DUTY_CENTER:
          cfg.duty_center <= cfg_data[gspd_pkg::DUTY_W-1:0];
        gspd_pkg::REG_KP_EXTRA:
          cfg.kp_extra <= cfg_data[gspd_pkg::EXTRA_W-1:0];
        gspd_pkg::REG_KD_EXTRA:
          cfg.kd_extra <= cfg_data[gspd_pkg::EXTRA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/gspd_gain_sched.sv -----
module gspd_gain_sched (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic signed [gspd_pkg::ERR_W-1:0]   err,
  input  logic                                obstacle_left,
  input  logic                                obstacle_right,
  input  gspd_pkg::cfg_t                      cfg,
  output gspd_pkg::gains_t                    gains
);

  localparam logic signed [gspd_pkg::ERR_W-1:0] EDGE_P =
    gspd_pkg::ERR_W'(gspd_pkg::BAND_EDGE);
  localparam logic signed [gspd_pkg::ERR_W-1:0] EDGE_N =
    gspd_pkg::ERR_W'(-gspd_pkg::BAND_EDGE);

  gspd_pkg::gains_t held;
  logic [gspd_pkg::GAIN_W-1:0] kp_large_right;
  logic [gspd_pkg::GAIN_W-1:0] kp_large_left;
  logic [gspd_pkg::GAIN_W-1:0] kd_large;

  assign kp_large_right = gspd_pkg::GAIN_W'(gspd_pkg::KP_RIGHT_SIDE)
                        + {1'b0, cfg.kp_extra};
  assign kp_large_left  = gspd_pkg::GAIN_W'(gspd_pkg::KP_LEFT_SIDE)
                        + {1'b0, cfg.kp_extra};
  assign kd_large       = gspd_pkg::GAIN_W'(gspd_pkg::KD_BASE)
                        + {1'b0, cfg.kd_extra};

  // obstacle overrides the band, right side over left
  always_comb begin
    gains = held;
    priority if (obstacle_right) begin
      gains.kp = gspd_pkg::GAIN_W'(gspd_pkg::KP_OBST_RIGHT);
      gains.kd = gspd_pkg::GAIN_W'(gspd_pkg::KD_OBST);
    end else if (obstacle_left) begin
      gains.kp = gspd_pkg::GAIN_W'(gspd_pkg::KP_OBST_LEFT);
      gains.kd = gspd_pkg::GAIN_W'(gspd_pkg::KD_OBST);
    end else if (err >= EDGE_P) begin
      gains.kp = kp_large_right;
      gains.kd = kd_large;
    end else if (err > 0) begin
      gains.kp = gspd_pkg::GAIN_W'(gspd_pkg::KP_RIGHT_SIDE);
      gains.kd = gspd_pkg::GAIN_W'(gspd_pkg::KD_BASE);
    end else if (err < EDGE_N) begin
      gains.kp = kp_large_left;
      gains.kd = kd_large;
    end else if (err < 0 && err != EDGE_N) begin
      gains.kp = gspd_pkg::GAIN_W'(gspd_pkg::KP_LEFT_SIDE);
      gains.kd = gspd_pkg::GAIN_W'(gspd_pkg::KD_BASE);
    end else begin
      // zero error and the left band edge keep the held gains
      gains = held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (advance) begin
      held <= gains;
    end
  end

endmodule

// ----- design/gspd_pd_calc.sv -----
module gspd_pd_calc (
  input  logic signed [gspd_pkg::ERR_W-1:0]   err,
  input  logic signed [gspd_pkg::ERR_W-1:0]   prev_err,
  input  gspd_pkg::gains_t                    gains,
  input  logic [gspd_pkg::DUTY_W-1:0]         duty_center,
  output logic [gspd_pkg::DUTY_W-1:0]         steer_duty
);

  localparam int unsigned SUM_W = 18;
  localparam logic signed [SUM_W-1:0] SPAN = SUM_W'(gspd_pkg::DUTY_SPAN);
  localparam logic signed [SUM_W-1:0] TOP  = SUM_W'(gspd_pkg::DUTY_MAX);

  logic signed [gspd_pkg::ERR_W:0]     diff;
  logic signed [2*gspd_pkg::ERR_W-1:0] p_term;
  logic signed [2*gspd_pkg::ERR_W:0]   d_term;
  logic signed [SUM_W-1:0]             center;
  logic signed [SUM_W-1:0]             duty;
  logic signed [SUM_W-1:0]             hi;
  logic signed [SUM_W-1:0]             lo;
  logic signed [SUM_W-1:0]             clamped;

  assign diff   = {err[gspd_pkg::ERR_W-1], err} - {prev_err[gspd_pkg::ERR_W-1], prev_err};
  assign p_term = $signed({1'b0, gains.kp}) * err;
  assign d_term = $signed({2'b00, gains.kd}) * diff;
  assign center = $signed({3'b000, duty_center});
  assign duty   = center + SUM_W'(p_term) + SUM_W'(d_term);
  assign hi     = center + SPAN;
  assign lo     = center - SPAN;

  // span clamp first, then the 15-bit range
  always_comb begin
    clamped = duty;
    if (clamped > hi) clamped = hi;
    if (clamped < lo) clamped = lo;
    if (clamped > TOP) clamped = TOP;
    if (clamped < 0) clamped = '0;
  end

  assign steer_duty = clamped[gspd_pkg::DUTY_W-1:0];

endmodule
